FILE: hdl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared defaults for the circle/segment penetration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  // Default coordinate width (two's complement, 8 fraction bits).
  localparam int COORD_WIDTH_DEF = 24;

  // Default number of fraction bits of the penetration ratio.
  localparam int RATIO_FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

FILE: hdl/csp_geom.sv
// ----------------------------------------------------------------------------
// csp_geom
// Three-stage front end: offsets, products, then sums and early rejection.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_geom
  import csp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                valid_in,
  input  logic signed [COORD_WIDTH-1:0]       mover_dx,
  input  logic signed [COORD_WIDTH-1:0]       mover_dy,
  input  logic signed [COORD_WIDTH-1:0]       wall_start_x,
  input  logic signed [COORD_WIDTH-1:0]       wall_start_y,
  input  logic signed [COORD_WIDTH-1:0]       wall_dx,
  input  logic signed [COORD_WIDTH-1:0]       wall_dy,
  input  logic signed [COORD_WIDTH-1:0]       center_x,
  input  logic signed [COORD_WIDTH-1:0]       center_y,
  input  logic        [COORD_WIDTH-2:0]       radius,
  output logic                                valid_out,
  output logic        [2*COORD_WIDTH-1:0]     sq_len,
  output logic        [2*COORD_WIDTH:0]       cross_mag,
  output logic        [COORD_WIDTH-2:0]       radius_out,
  output logic                                reject
);

  localparam int AW  = COORD_WIDTH + 1;
  localparam int BW  = COORD_WIDTH + 2;
  localparam int PW  = 2 * COORD_WIDTH + 4;
  localparam int SW  = 2 * COORD_WIDTH;
  localparam int CLW = 2 * COORD_WIDTH + 1;

  // Stage 1: offsets of both wall ends from the center.
  logic                          v1;
  logic signed [AW-1:0]          ax, ay;
  logic signed [BW-1:0]          bx, by;
  logic signed [COORD_WIDTH-1:0] mx, my, wx, wy;
  logic        [COORD_WIDTH-2:0] r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= AW'(wall_start_x) - AW'(center_x);
      ay <= AW'(wall_start_y) - AW'(center_y);
      bx <= BW'(wall_start_x) - BW'(center_x) + BW'(wall_dx);
      by <= BW'(wall_start_y) - BW'(center_y) + BW'(wall_dy);
      mx <= mover_dx;
      my <= mover_dy;
      wx <= wall_dx;
      wy <= wall_dy;
      r1 <= radius;
    end
  end

  // Stage 2: every product, one multiplier each.
  logic                 v2;
  logic signed [PW-1:0] p_mxwy, p_mywx, p_wxwx, p_wywy, p_wxay, p_wyax;
  logic signed [PW-1:0] p_wxax, p_wyay, p_axax, p_ayay, p_bxbx, p_byby, p_rr;
  logic [COORD_WIDTH-2:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mxwy <= PW'(mx) * PW'(wy);
      p_mywx <= PW'(my) * PW'(wx);
      p_wxwx <= PW'(wx) * PW'(wx);
      p_wywy <= PW'(wy) * PW'(wy);
      p_wxay <= PW'(wx) * PW'(ay);
      p_wyax <= PW'(wy) * PW'(ax);
      p_wxax <= PW'(wx) * PW'(ax);
      p_wyay <= PW'(wy) * PW'(ay);
      p_axax <= PW'(ax) * PW'(ax);
      p_ayay <= PW'(ay) * PW'(ay);
      p_bxbx <= PW'(bx) * PW'(bx);
      p_byby <= PW'(by) * PW'(by);
      p_rr   <= PW'($signed({1'b0, r1})) * PW'($signed({1'b0, r1}));
      r2     <= r1;
    end
  end

  // Stage 3: sums, magnitudes and the rejection tests that need no distance.
  logic signed [PW-1:0] cross_mw, s_full, cr, cr_mag, dot_a, dot_b;
  logic signed [PW-1:0] dist_a, dist_b;
  logic                 same_side, in_a, in_b, rej_c;

  always_comb begin
    cross_mw  = p_mxwy - p_mywx;
    s_full    = p_wxwx + p_wywy;
    cr        = p_wxay - p_wyax;
    cr_mag    = cr[PW-1] ? -cr : cr;
    dot_a     = p_wxax + p_wyay;
    dot_b     = dot_a + s_full;
    dist_a    = p_axax + p_ayay;
    dist_b    = p_bxbx + p_byby;
    in_a      = p_rr > dist_a;
    in_b      = p_rr > dist_b;
    same_side = (dot_a != '0) && (dot_b != '0) && (dot_a[PW-1] == dot_b[PW-1]);
    rej_c     = cross_mw[PW-1] || (s_full == '0) || (r2 == '0) ||
                (same_side && !in_a && !in_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_len     <= s_full[SW-1:0];
      cross_mag  <= cr_mag[CLW-1:0];
      radius_out <= r2;
      reject     <= rej_c;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/csp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// csp_sqrt_cell
// One step of a digit-by-digit integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_sqrt_cell
  import csp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int SIDE_W      = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic [2*COORD_WIDTH-1:0]   rad_in,
  input  logic [COORD_WIDTH+1:0]     rem_in,
  input  logic [COORD_WIDTH-1:0]     root_in,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       valid_out,
  output logic [2*COORD_WIDTH-1:0]   rad_out,
  output logic [COORD_WIDTH+1:0]     rem_out,
  output logic [COORD_WIDTH-1:0]     root_out,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int SW = 2 * COORD_WIDTH;
  localparam int TW = COORD_WIDTH + 4;

  logic [TW-1:0] shifted, trial, diff;
  logic          ge;

  always_comb begin
    shifted = {rem_in, rad_in[SW-1 -: 2]};
    trial   = {2'b00, root_in, 2'b01};
    diff    = shifted - trial;
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[SW-3:0], 2'b00};
      rem_out  <= ge ? diff[COORD_WIDTH+1:0] : shifted[COORD_WIDTH+1:0];
      root_out <= {root_in[COORD_WIDTH-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/csp_div_cell.sv
// ----------------------------------------------------------------------------
// csp_div_cell
// One step of restoring long division: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_div_cell #(
  parameter int NUM_W  = 8,
  parameter int DIV_W  = 8,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DIV_W-1:0]  rem_in,
  input  logic [QUO_W-1:0]  quo_in,
  input  logic [DIV_W-1:0]  dvs_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [NUM_W-1:0]  num_out,
  output logic [DIV_W-1:0]  rem_out,
  output logic [QUO_W-1:0]  quo_out,
  output logic [DIV_W-1:0]  dvs_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [DIV_W:0] shifted, diff;
  logic           ge;

  always_comb begin
    shifted = {rem_in, num_in[NUM_W-1]};
    diff    = shifted - {1'b0, dvs_in};
    ge      = shifted >= {1'b0, dvs_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out  <= {num_in[NUM_W-2:0], 1'b0};
      rem_out  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_out  <= {quo_in[QUO_W-2:0], ge};
      dvs_out  <= dvs_in;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/circle_segment_penetration.sv
// ----------------------------------------------------------------------------
// circle_segment_penetration
// Pipelined penetration ratio of a moving circle into a wall segment.
// ----------------------------------------------------------------------------
// Usage: a query item (mover direction, wall start and vector, circle center
// and radius) is taken on the query channel when query_valid is high and
// query_stall is low. Exactly one result item (penetration, hit) leaves on
// the result channel for each query, in order, when result_valid is high and
// result_stall is low.
// Throughput is one item per cycle while no waiting result is stalled. The
// pipeline holds three front-end stages, COORD_WIDTH square root cells for
// the wall length, 2*COORD_WIDTH+1 divider cells for the distance, one
// compare stage and COORD_WIDTH-1+RATIO_FRAC_BITS divider cells for the ratio.
// The last ratio cell is the output register.
// Reset empties every stage; no result is pending afterward.
// When the receiver stalls a waiting result, the whole chain holds and
// query_stall is raised in the same cycle; an empty output never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_segment_penetration
  import csp_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          query_valid,
  output logic                          query_stall,
  input  logic signed [COORD_WIDTH-1:0] mover_dx,
  input  logic signed [COORD_WIDTH-1:0] mover_dy,
  input  logic signed [COORD_WIDTH-1:0] wall_start_x,
  input  logic signed [COORD_WIDTH-1:0] wall_start_y,
  input  logic signed [COORD_WIDTH-1:0] wall_dx,
  input  logic signed [COORD_WIDTH-1:0] wall_dy,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [COORD_WIDTH-2:0] radius,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [RATIO_FRAC_BITS:0]      penetration,
  output logic                          hit
);

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = 2 * CW;
  localparam int CLW  = 2 * CW + 1;
  localparam int SQ_SIDE = CLW + CW;
  localparam int RNW  = CW - 1 + RATIO_FRAC_BITS;
  localparam int QW   = RATIO_FRAC_BITS + 1;

  // The chain advances unless a finished result is being held back.
  logic en;
  assign en          = !(result_valid && result_stall);
  assign query_stall = !en;

  // Front end.
  logic            g_valid, g_reject;
  logic [SW-1:0]   g_sq_len;
  logic [CLW-1:0]  g_cross;
  logic [CW-2:0]   g_radius;

  csp_geom #(.COORD_WIDTH(CW)) u_geom (
    .clk, .rst, .en,
    .valid_in     (query_valid),
    .mover_dx, .mover_dy, .wall_start_x, .wall_start_y,
    .wall_dx, .wall_dy, .center_x, .center_y, .radius,
    .valid_out    (g_valid),
    .sq_len       (g_sq_len),
    .cross_mag    (g_cross),
    .radius_out   (g_radius),
    .reject       (g_reject)
  );

  // Wall length: floor(sqrt(sq_len)), one root bit per cell. The side data
  // carries the cross magnitude, the radius and the reject flag along.
  logic               sq_v    [0:CW];
  logic [SW-1:0]      sq_rad  [0:CW];
  logic [CW+1:0]      sq_rem  [0:CW];
  logic [CW-1:0]      sq_root [0:CW];
  logic [SQ_SIDE-1:0] sq_side [0:CW];

  assign sq_v[0]    = g_valid;
  assign sq_rad[0]  = g_sq_len;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {g_cross, g_radius, g_reject};

  for (genvar i = 0; i < CW; i++) begin : g_sqrt
    csp_sqrt_cell #(.COORD_WIDTH(CW), .SIDE_W(SQ_SIDE)) u_cell (
      .clk, .rst, .en,
      .valid_in  (sq_v[i]),
      .rad_in    (sq_rad[i]),
      .rem_in    (sq_rem[i]),
      .root_in   (sq_root[i]),
      .side_in   (sq_side[i]),
      .valid_out (sq_v[i+1]),
      .rad_out   (sq_rad[i+1]),
      .rem_out   (sq_rem[i+1]),
      .root_out  (sq_root[i+1]),
      .side_out  (sq_side[i+1])
    );
  end

  // Perpendicular distance: cross magnitude divided by the wall length.
  logic           d_v    [0:CLW];
  logic [CLW-1:0] d_num  [0:CLW];
  logic [CW-1:0]  d_rem  [0:CLW];
  logic [CLW-1:0] d_quo  [0:CLW];
  logic [CW-1:0]  d_dvs  [0:CLW];
  logic [CW-1:0]  d_side [0:CLW];

  assign d_v[0]    = sq_v[CW];
  assign d_num[0]  = sq_side[CW][SQ_SIDE-1 -: CLW];
  assign d_rem[0]  = '0;
  assign d_quo[0]  = '0;
  assign d_dvs[0]  = sq_root[CW];
  assign d_side[0] = sq_side[CW][CW-1:0];

  for (genvar i = 0; i < CLW; i++) begin : g_dist
    csp_div_cell #(.NUM_W(CLW), .DIV_W(CW), .QUO_W(CLW), .SIDE_W(CW)) u_cell (
      .clk, .rst, .en,
      .valid_in  (d_v[i]),
      .num_in    (d_num[i]),
      .rem_in    (d_rem[i]),
      .quo_in    (d_quo[i]),
      .dvs_in    (d_dvs[i]),
      .side_in   (d_side[i]),
      .valid_out (d_v[i+1]),
      .num_out   (d_num[i+1]),
      .rem_out   (d_rem[i+1]),
      .quo_out   (d_quo[i+1]),
      .dvs_out   (d_dvs[i+1]),
      .side_out  (d_side[i+1])
    );
  end

  // Judge stage: a hit needs no earlier rejection and a distance within the
  // radius. Without a hit the ratio divider sees 0 / 1, which yields 0.
  logic [CLW-1:0] perp_dist;
  logic [CW-2:0]  d_radius;
  logic           d_reject, hit_c;

  always_comb begin
    perp_dist = d_quo[CLW];
    d_radius  = d_side[CLW][CW-1:1];
    d_reject  = d_side[CLW][0];
    hit_c     = !d_reject && (perp_dist <= CLW'(d_radius));
  end

  logic          j_valid, j_hit;
  logic [CW-2:0] j_num, j_dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (en) begin
      j_valid <= d_v[CLW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_hit <= hit_c;
      j_num <= hit_c ? (d_radius - perp_dist[CW-2:0]) : '0;
      j_dvs <= hit_c ? d_radius : (CW-1)'(1);
    end
  end

  // Ratio: ((radius - distance) << RATIO_FRAC_BITS) / radius.
  logic            r_v    [0:RNW];
  logic [RNW-1:0]  r_num  [0:RNW];
  logic [CW-2:0]   r_rem  [0:RNW];
  logic [QW-1:0]   r_quo  [0:RNW];
  logic [CW-2:0]   r_dvs  [0:RNW];
  logic            r_side [0:RNW];

  assign r_v[0]    = j_valid;
  assign r_num[0]  = {j_num, {RATIO_FRAC_BITS{1'b0}}};
  assign r_rem[0]  = '0;
  assign r_quo[0]  = '0;
  assign r_dvs[0]  = j_dvs;
  assign r_side[0] = j_hit;

  for (genvar i = 0; i < RNW; i++) begin : g_ratio
    csp_div_cell #(.NUM_W(RNW), .DIV_W(CW-1), .QUO_W(QW), .SIDE_W(1)) u_cell (
      .clk, .rst, .en,
      .valid_in  (r_v[i]),
      .num_in    (r_num[i]),
      .rem_in    (r_rem[i]),
      .quo_in    (r_quo[i]),
      .dvs_in    (r_dvs[i]),
      .side_in   (r_side[i]),
      .valid_out (r_v[i+1]),
      .num_out   (r_num[i+1]),
      .rem_out   (r_rem[i+1]),
      .quo_out   (r_quo[i+1]),
      .dvs_out   (r_dvs[i+1]),
      .side_out  (r_side[i+1])
    );
  end

  assign result_valid = r_v[RNW];
  assign penetration  = r_quo[RNW];
  assign hit          = r_side[RNW];

endmodule

`default_nettype wire

FILE: hdl/csp_checker.sv
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks of the penetration pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_checker
  import csp_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     query_stall,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic [RATIO_FRAC_BITS:0] penetration,
  input  logic                     hit
);

  localparam logic [RATIO_FRAC_BITS:0] ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  // A miss never reports a ratio.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !hit) |-> (penetration == '0))
    else $error("miss with nonzero penetration");

  // The ratio never exceeds one.
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (penetration <= ONE))
    else $error("penetration above one");

  // Queries are only held back by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    query_stall |-> (result_valid && result_stall))
    else $error("query stalled without a blocked result");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(penetration) && $stable(hit)))
    else $error("stalled result changed");

endmodule

bind circle_segment_penetration csp_checker #(
  .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
) u_csp_checker (
  .clk          (clk),
  .rst          (rst),
  .query_stall  (query_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .penetration  (penetration),
  .hit          (hit)
);

`default_nettype wire
